[hdl/gae_advantage_scan_macros.svh]
// Assertion shorthands shared by the RTL.
// Both assume a clock named clk and an active-low reset named rst_n.
`ifndef GAE_ADVANTAGE_SCAN_MACROS_SVH
`define GAE_ADVANTAGE_SCAN_MACROS_SVH

// Consequent checked in the same cycle.
`define GAE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the next cycle.
`define GAE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/gae_pkg.sv]
package gae_pkg;

    localparam int AGENTS     = 256;              // power of two
    localparam int ADDR_W     = $clog2(AGENTS);
    localparam int AGENT_W    = 8;
    localparam int DATA_W     = 32;
    localparam int GAIN_W     = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int FRAC_W     = 16;
    localparam int PROD_W     = 50;
    localparam int RND_W      = PROD_W - FRAC_W;
    localparam int SUM_W      = 35;
    localparam int ENTRY_W    = 2 * DATA_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1 << FRAC_W);
    localparam logic [GAIN_W-1:0] DISCOUNT_RST = GAIN_W'(64881);
    localparam logic [GAIN_W-1:0] DECAY_RST    = GAIN_W'(62259);
    localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1 << (FRAC_W - 1));

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

    typedef logic [GAIN_W-1:0] gain_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DISCOUNT      = 2'd0,
        REG_TRACE_DECAY   = 2'd1,
        REG_USE_BOOTSTRAP = 2'd2
    } cfg_reg_t;

    // Settings handed from the register block to the datapath.
    typedef struct packed {
        gain_t gamma;      // clamped discount
        gain_t gain;       // rounded gamma * lambda
        logic  use_boot;
    } cfg_t;

    function automatic gain_t clamp_gain(input gain_t g);
        return (g > GAIN_ONE) ? GAIN_ONE : g;
    endfunction

    // Round half up to Q16.16, floor of (x + 2^15) / 2^16.
    function automatic logic signed [RND_W-1:0] round_q16(
        input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] s;
        s = x + RND_HALF;
        return s[PROD_W-1:FRAC_W];
    endfunction

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > SAT_HI) begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (x < SAT_LO) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = x[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

[hdl/gae_advantage_scan.sv]
// Generalized advantage estimation over reverse-time rollout samples.
// Input channel: one sample beat per in_valid/!in_stall edge; agents may be
// interleaved freely, each agent's samples arrive newest step first, and the
// first one per agent must carry final_step.
// Output channel: one advantage beat per input beat, in input order, tagged
// with agent_out. Taken on out_valid/!out_stall.
// Config: cfg_write with cfg_index/cfg_data writes gamma, lambda or the
// bootstrap enable; write only while no beat is in flight.
// Pipeline: accept (state RAM read) -> TD error -> advantage and RAM
// write-back -> output register, each stage registered in that order.
// Throughput is one beat per cycle while out_stall does not back up the
// pipeline, also for the same agent back to back: the advantage stage's
// write-back is forwarded into the two younger stages, so the per-agent
// recurrence closes through a single multiply-add in the advantage stage.
// Out stall: the output register holds; the advantage and TD stages keep
// draining into empty slots, and in_stall rises only when the TD stage is
// full and cannot move.
// Reset: valids clear and the registers return to gamma 64881, lambda 62259,
// bootstrap on. The per-agent state RAM is not cleared; no clearing pass.
`include "gae_advantage_scan_macros.svh"

module gae_advantage_scan (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [gae_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gae_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [gae_pkg::AGENT_W-1:0]         agent_index,
    input  logic                                final_step,
    input  logic signed [gae_pkg::DATA_W-1:0]   state_value,
    input  logic signed [gae_pkg::DATA_W-1:0]   step_reward,
    input  logic                                episode_done,
    input  logic                                bootstrap_hit,
    input  logic signed [gae_pkg::DATA_W-1:0]   bootstrap_estimate,
    input  logic signed [gae_pkg::DATA_W-1:0]   tail_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [gae_pkg::DATA_W-1:0]   advantage,
    output logic [gae_pkg::AGENT_W-1:0]         agent_out
);
    import gae_pkg::*;

    cfg_t cfg;

    gae_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ---------------- handshake ----------------
    logic in_accept;
    logic s1_move;
    logic s2_fire;

    // ---------------- state RAM ----------------
    // Entry = {running advantage, following value}.
    logic [ENTRY_W-1:0] mem [AGENTS];
    logic [ENTRY_W-1:0] rd_reg;
    logic [ADDR_W-1:0]  in_addr;

    // ---------------- TD stage ----------------
    logic                     s1_v_reg, s1_v_next;
    logic [AGENT_W-1:0]       s1_agent_reg;
    logic                     s1_final_reg;
    logic signed [DATA_W-1:0] s1_value_reg;
    logic signed [DATA_W-1:0] s1_reward_reg;
    logic                     s1_done_reg;
    logic                     s1_boot_reg;
    logic signed [DATA_W-1:0] s1_est_reg;
    logic signed [DATA_W-1:0] s1_tail_reg;
    logic                     s1_fhit_reg;     // entry superseded by a later write
    logic signed [DATA_W-1:0] s1_fadv_reg;
    logic signed [DATA_W-1:0] s1_fval_reg;

    logic                     fwd_s1;
    logic signed [DATA_W-1:0] eff_adv;
    logic signed [DATA_W-1:0] eff_val;
    logic                     use_est;
    logic                     keep_next;
    logic signed [DATA_W-1:0] next_val;
    logic signed [DATA_W-1:0] prev_val;
    logic signed [PROD_W-1:0] disc_prod;
    logic signed [RND_W-1:0]  disc_rnd;
    logic signed [SUM_W-1:0]  delta_sum;
    logic signed [DATA_W-1:0] delta_sat;

    // ---------------- advantage stage ----------------
    logic                     s2_v_reg, s2_v_next;
    logic [AGENT_W-1:0]       s2_agent_reg;
    logic signed [DATA_W-1:0] s2_value_reg;
    logic                     s2_done_reg;
    logic signed [DATA_W-1:0] s2_delta_reg;
    logic signed [DATA_W-1:0] s2_prev_reg;

    logic signed [PROD_W-1:0] carry_prod;
    logic signed [RND_W-1:0]  carry_rnd;
    logic signed [SUM_W-1:0]  adv_sum;
    logic signed [DATA_W-1:0] adv_comb;

    // ---------------- output register ----------------
    logic                     out_v_reg, out_v_next;
    logic signed [DATA_W-1:0] adv_out_reg;
    logic [AGENT_W-1:0]       agent_out_reg;

    assign s2_fire   = s2_v_reg && (!out_v_reg || !out_stall);
    assign s1_move   = s1_v_reg && (!s2_v_reg || s2_fire);
    assign in_stall  = s1_v_reg && !s1_move;
    assign in_accept = in_valid && !in_stall;
    assign in_addr   = agent_index[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            mem[s2_agent_reg[ADDR_W-1:0]] <= {adv_comb, s2_value_reg};
        end
        if (in_accept)
        begin
            rd_reg <= mem[in_addr];
        end
    end

    // ---------------- TD error ----------------
    // A write landing this cycle on the same agent wins over the read data.
    assign fwd_s1  = s2_fire && (s2_agent_reg[ADDR_W-1:0] == s1_agent_reg[ADDR_W-1:0]);
    assign eff_adv = fwd_s1 ? adv_comb
                   : (s1_fhit_reg ? s1_fadv_reg : $signed(rd_reg[ENTRY_W-1:DATA_W]));
    assign eff_val = fwd_s1 ? s2_value_reg
                   : (s1_fhit_reg ? s1_fval_reg : $signed(rd_reg[DATA_W-1:0]));

    assign use_est   = s1_boot_reg && cfg.use_boot;
    assign keep_next = use_est || !s1_done_reg;
    assign next_val  = use_est ? s1_est_reg : (s1_final_reg ? s1_tail_reg : eff_val);
    assign prev_val  = s1_final_reg ? '0 : eff_adv;

    assign disc_prod = $signed({1'b0, cfg.gamma}) * next_val;
    assign disc_rnd  = round_q16(disc_prod);
    assign delta_sum = SUM_W'(s1_reward_reg) - SUM_W'(s1_value_reg)
                     + (keep_next ? SUM_W'(disc_rnd) : SUM_W'(0));
    assign delta_sat = sat32(delta_sum);

    always_comb
    begin
        s1_v_next = s1_v_reg;
        if (in_accept)
        begin
            s1_v_next = 1'b1;
        end
        else if (s1_move)
        begin
            s1_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_agent_reg  <= agent_index;
            s1_final_reg  <= final_step;
            s1_value_reg  <= state_value;
            s1_reward_reg <= step_reward;
            s1_done_reg   <= episode_done;
            s1_boot_reg   <= bootstrap_hit;
            s1_est_reg    <= bootstrap_estimate;
            s1_tail_reg   <= tail_value;
            // RAM read sees the old entry when the write hits the same edge
            s1_fhit_reg   <= s2_fire && (s2_agent_reg[ADDR_W-1:0] == in_addr);
            s1_fadv_reg   <= adv_comb;
            s1_fval_reg   <= s2_value_reg;
        end
        else if (s1_v_reg && !s1_move && fwd_s1)
        begin
            s1_fhit_reg <= 1'b1;
            s1_fadv_reg <= adv_comb;
            s1_fval_reg <= s2_value_reg;
        end
    end

    // ---------------- advantage ----------------
    assign carry_prod = $signed({1'b0, cfg.gain}) * s2_prev_reg;
    assign carry_rnd  = round_q16(carry_prod);
    assign adv_sum    = SUM_W'(s2_delta_reg) + (s2_done_reg ? SUM_W'(0) : SUM_W'(carry_rnd));
    assign adv_comb   = sat32(adv_sum);

    always_comb
    begin
        s2_v_next = s2_v_reg;
        if (s1_move)
        begin
            s2_v_next = 1'b1;
        end
        else if (s2_fire)
        begin
            s2_v_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_agent_reg <= s1_agent_reg;
            s2_value_reg <= s1_value_reg;
            s2_done_reg  <= s1_done_reg;
            s2_delta_reg <= delta_sat;
            s2_prev_reg  <= prev_val;
        end
    end

    // ---------------- output ----------------
    always_comb
    begin
        out_v_next = out_v_reg && out_stall;
        if (s2_fire)
        begin
            out_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            adv_out_reg   <= adv_comb;
            agent_out_reg <= s2_agent_reg;
        end
    end

    assign out_valid = out_v_reg;
    assign advantage = adv_out_reg;
    assign agent_out = agent_out_reg;

    // ---------------- checks ----------------
    `GAE_ASSERT_NEXT(a_fwd_into_adv_stage,
        s1_move && fwd_s1 && !s1_final_reg,
        s2_prev_reg == $past(adv_comb),
        "advantage stage missed forwarded advantage")

    `GAE_ASSERT_NEXT(a_fwd_on_accept,
        in_accept && s2_fire && (s2_agent_reg[ADDR_W-1:0] == in_addr),
        s1_fhit_reg && (s1_fval_reg == $past(s2_value_reg)),
        "write on the read edge not captured")

    `GAE_ASSERT_NEXT(a_writeback_to_output,
        s2_fire,
        out_v_reg && (agent_out_reg == $past(s2_agent_reg)),
        "write-back without matching output beat")

    `GAE_ASSERT_NOW(a_stall_needs_full_td,
        in_stall,
        s1_v_reg && s2_v_reg && out_v_reg && out_stall,
        "input stalled with room in the pipeline")

endmodule

[hdl/gae_cfg.sv]
module gae_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [gae_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gae_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gae_pkg::cfg_t                   cfg
);
    import gae_pkg::*;

    gain_t discount_reg;
    gain_t trace_decay_reg;
    logic  use_boot_reg;
    gain_t gain_reg;

    gain_t                    gamma_c;
    gain_t                    lambda_c;
    logic signed [PROD_W-1:0] gain_prod;
    logic signed [RND_W-1:0]  gain_rnd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            discount_reg    <= DISCOUNT_RST;
            trace_decay_reg <= DECAY_RST;
            use_boot_reg    <= 1'b1;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DISCOUNT:      discount_reg    <= cfg_data[GAIN_W-1:0];
                REG_TRACE_DECAY:   trace_decay_reg <= cfg_data[GAIN_W-1:0];
                REG_USE_BOOTSTRAP: use_boot_reg    <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    assign gamma_c   = clamp_gain(discount_reg);
    assign lambda_c  = clamp_gain(trace_decay_reg);
    assign gain_prod = $signed({1'b0, gamma_c}) * $signed({1'b0, lambda_c});
    assign gain_rnd  = round_q16(gain_prod);

    // Combined decay, re-evaluated every cycle; registered, so it settles in the cycle after a write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
        end
        else
        begin
            gain_reg <= gain_rnd[GAIN_W-1:0];
        end
    end

    assign cfg.gamma    = gamma_c;
    assign cfg.gain     = gain_reg;
    assign cfg.use_boot = use_boot_reg;

endmodule

[dv/tb_top.sv]
module tb_top;

    import gae_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int DIR_ROWS      = 17;
    localparam int FIRST_RANDOM  = 220;   // random beats after the directed rows
    localparam int PHASE_BEATS   = 240;   // random beats per later config setting
    localparam int CFG_PHASES    = 8;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int IDLE_LIMIT    = 3000;  // watchdog: cycles with no beat on either side
    localparam int PIPE_SETTLE   = 4;     // margin for the pipeline to settle

    // One input beat, plus an optional hand-computed advantage for
    // the directed rows.
    typedef struct packed {
        logic [AGENT_W-1:0]        agent;
        logic                      fin;
        logic signed [DATA_W-1:0]  value;
        logic signed [DATA_W-1:0]  reward;
        logic                      done;
        logic                      hit;
        logic signed [DATA_W-1:0]  boot;
        logic signed [DATA_W-1:0]  tail;
        logic                      fixed_exp;
        logic signed [DATA_W-1:0]  exp_adv;
    } sample_t;

    typedef struct {
        logic signed [DATA_W-1:0]  adv;
        logic [AGENT_W-1:0]        agent;
    } adv_exp_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_write;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          in_valid;
    logic                          in_stall;
    logic [AGENT_W-1:0]            agent_index;
    logic                          final_step;
    logic signed [DATA_W-1:0]      state_value;
    logic signed [DATA_W-1:0]      step_reward;
    logic                          episode_done;
    logic                          bootstrap_hit;
    logic signed [DATA_W-1:0]      bootstrap_estimate;
    logic signed [DATA_W-1:0]      tail_value;
    logic                          out_valid;
    logic                          out_stall;
    logic signed [DATA_W-1:0]      advantage;
    logic [AGENT_W-1:0]            agent_out;

    // Shadow of the block: config registers and per-agent columns.
    gain_t                         discount_q;
    gain_t                         decay_q;
    logic                          boot_en_q;
    logic signed [DATA_W-1:0]      adv_mem      [AGENTS];
    logic signed [DATA_W-1:0]      next_val_mem [AGENTS];
    bit                            agent_live   [AGENTS];   // column written since reset

    adv_exp_t                      pending_adv[$];
    sample_t                       dir_rows [DIR_ROWS];
    logic [AGENT_W-1:0]            agent_pool [8];
    int                            n_errors;
    int                            idle_cycles;
    int                            burst_left;
    int                            hold_reqs;     // bumped by the stimulus thread only

    gae_advantage_scan u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write          (cfg_write),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .agent_index        (agent_index),
        .final_step         (final_step),
        .state_value        (state_value),
        .step_reward        (step_reward),
        .episode_done       (episode_done),
        .bootstrap_hit      (bootstrap_hit),
        .bootstrap_estimate (bootstrap_estimate),
        .tail_value         (tail_value),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .advantage          (advantage),
        .agent_out          (agent_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor arithmetic
    // ------------------------------------------------------------------

    // Q16.16 rescale, round half up: floor((x + 2^15) / 2^16).
    function automatic longint half_up_q16(input longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic longint clip32(input longint x);
        if (x > 64'sh7FFF_FFFF)
            return 64'sh7FFF_FFFF;
        if (x < -64'sh8000_0000)
            return -64'sh8000_0000;
        return x;
    endfunction

    // Advantage for one beat; updates the agent's column like the block does.
    function automatic logic signed [DATA_W-1:0] predict_advantage(input sample_t s);
        longint gamma;
        longint lambda;
        longint nxt;
        longint prv;
        longint delta;
        longint gl;
        longint carry;
        longint adv;
        bit     keep_next;
        // gains above 1.0 are clamped to exactly 1.0
        gamma  = (discount_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(discount_q);
        lambda = (decay_q > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(decay_q);
        nxt = s.fin ? longint'($signed(s.tail)) : longint'(next_val_mem[s.agent]);
        prv = s.fin ? 64'sd0 : longint'(adv_mem[s.agent]);
        keep_next = 1'b1;
        // bootstrap overrides next and ignores done for the TD term
        if (s.hit && boot_en_q)
            nxt = longint'($signed(s.boot));
        else if (s.done)
            keep_next = 1'b0;
        delta = longint'($signed(s.reward)) - longint'($signed(s.value))
              + (keep_next ? half_up_q16(gamma * nxt) : 64'sd0);
        delta = clip32(delta);
        gl    = half_up_q16(gamma * lambda);
        carry = s.done ? 64'sd0 : half_up_q16(gl * prv);
        adv   = clip32(delta + carry);
        adv_mem[s.agent]      = adv[DATA_W-1:0];
        next_val_mem[s.agent] = s.value;
        agent_live[s.agent]   = 1'b1;
        return adv[DATA_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Q16.16 operand: small magnitudes most of the time, plus full range
    // and the corner values so that every bit toggles and saturation hits.
    function automatic logic signed [DATA_W-1:0] rand_q16();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2)
            return $urandom;
        if (r == 2)
        begin
            case ($urandom_range(0, 3))
                0: return 32'h7FFF_FFFF;
                1: return 32'h8000_0000;
                2: return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
    endfunction

    // Well-formed reverse-time trajectories: an agent's first beat since
    // reset always carries final_step, later beats mostly continue it.
    function automatic sample_t rand_sample();
        sample_t s;
        if ($urandom_range(0, 9) < 7)
            s.agent = agent_pool[$urandom_range(0, 7)];
        else
            s.agent = AGENT_W'($urandom_range(0, AGENTS - 1));
        s.fin       = agent_live[s.agent] ? ($urandom_range(0, 9) == 0) : 1'b1;
        s.value     = rand_q16();
        s.reward    = rand_q16();
        s.done      = ($urandom_range(0, 4) == 0);
        s.hit       = ($urandom_range(0, 9) < 3);
        s.boot      = rand_q16();
        s.tail      = rand_q16();
        s.fixed_exp = 1'b0;
        s.exp_adv   = '0;
        return s;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(input sample_t s);
        adv_exp_t e;
        int       gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 49) == 0)
                burst_left = $urandom_range(10, 50);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        agent_index        <= s.agent;
        final_step         <= s.fin;
        state_value        <= s.value;
        step_reward        <= s.reward;
        episode_done       <= s.done;
        bootstrap_hit      <= s.hit;
        bootstrap_estimate <= s.boot;
        tail_value         <= s.tail;
        in_valid           <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        e.adv   = predict_advantage(s);
        e.agent = s.agent;
        if (s.fixed_exp)
            e.adv = s.exp_adv;
        pending_adv.push_back(e);
        @(negedge clk);
    endtask

    // Drop valid and wait for every outstanding advantage, then let the
    // pipeline settle before touching config.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_adv.size() != 0)
            @(negedge clk);
        repeat (PIPE_SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DISCOUNT:      discount_q = val;
            REG_TRACE_DECAY:   decay_q    = val;
            REG_USE_BOOTSTRAP: boot_en_q  = val[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Config settings per phase: zero gains, unity, beyond unity (clamped),
    // just above unity, random, near-typical and tiny gamma.
    task automatic apply_phase_config(input int phase);
        case (phase)
            1:
            begin
                write_reg(REG_DISCOUNT, 17'd0);
                write_reg(REG_TRACE_DECAY, 17'd0);
                write_reg(REG_USE_BOOTSTRAP, 17'd0);
            end
            2:
            begin
                write_reg(REG_DISCOUNT, 17'd65536);
                write_reg(REG_TRACE_DECAY, 17'd65536);
                write_reg(REG_USE_BOOTSTRAP, 17'd1);
            end
            3:
            begin
                write_reg(REG_DISCOUNT, 17'h1FFFF);
                write_reg(REG_TRACE_DECAY, 17'h1FFFF);
                write_reg(REG_USE_BOOTSTRAP, 17'd0);
            end
            4:
            begin
                write_reg(REG_DISCOUNT, 17'd65537);
                write_reg(REG_TRACE_DECAY, 17'd100000);
                write_reg(REG_USE_BOOTSTRAP, 17'd1);
            end
            5:
            begin
                write_reg(REG_DISCOUNT, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
                write_reg(REG_TRACE_DECAY, CFG_DATA_W'($urandom_range(0, 17'h1FFFF)));
                write_reg(REG_USE_BOOTSTRAP, CFG_DATA_W'($urandom_range(0, 1)));
            end
            6:
            begin
                write_reg(REG_DISCOUNT, CFG_DATA_W'($urandom_range(60000, 65536)));
                write_reg(REG_TRACE_DECAY, CFG_DATA_W'($urandom_range(55000, 65536)));
                write_reg(REG_USE_BOOTSTRAP, 17'd1);
            end
            default:
            begin
                write_reg(REG_DISCOUNT, 17'd1);
                write_reg(REG_TRACE_DECAY, 17'd65535);
                write_reg(REG_USE_BOOTSTRAP, 17'd1);
            end
        endcase
        cfg_write <= 1'b0;
    endtask

    task automatic run_random(input int n_beats, input int hold_at);
        for (int i = 0; i < n_beats; i++)
        begin
            // ask the receiver for a long hold-off while beats keep coming,
            // so the pipeline backs up into in_stall
            if (i == hold_at)
                hold_reqs++;
            send_beat(rand_sample());
        end
    endtask

    // ------------------------------------------------------------------
    // Main stimulus thread
    // ------------------------------------------------------------------
    initial
    begin
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = REG_DISCOUNT;
        cfg_data           = '0;
        in_valid           = 1'b0;
        agent_index        = '0;
        final_step         = 1'b0;
        state_value        = '0;
        step_reward        = '0;
        episode_done       = 1'b0;
        bootstrap_hit      = 1'b0;
        bootstrap_estimate = '0;
        tail_value         = '0;
        discount_q         = DISCOUNT_RST;
        decay_q            = DECAY_RST;
        boot_en_q          = 1'b1;
        n_errors           = 0;
        burst_left         = 0;
        hold_reqs          = 0;
        for (int a = 0; a < AGENTS; a++)
        begin
            adv_mem[a]      = '0;
            next_val_mem[a] = '0;
            agent_live[a]   = 1'b0;
        end

        // Directed rows at the reset config (gamma 64881, lambda 62259,
        // bootstrap on). Hand values only where done kills both the next
        // value and the carry, or where tail and prev are zero.
        //   agent fin  value         reward        done hit boot          tail
        dir_rows = '{
            // small terminal step: reward - value
            '{8'd0,   1'b1, 32'h0000_0002, 32'h0000_0005, 1'b1, 1'b0, 32'h0, 32'h0,
              1'b1, 32'h0000_0003},
            // positive saturation on the TD error
            '{8'd255, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0,
              1'b1, 32'h7FFF_FFFF},
            // negative saturation on the TD error
            '{8'd128, 1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0, 32'h0, 32'h0,
              1'b1, 32'h8000_0000},
            // final step, zero tail, not done
            '{8'd1,   1'b1, 32'h0001_0000, 32'h0003_0000, 1'b0, 1'b0, 32'h0, 32'h0,
              1'b1, 32'h0002_0000},
            // plain continuation, same agent back to back
            '{8'd1,   1'b0, 32'h0002_8000, 32'h0000_4000, 1'b0, 1'b0, 32'h0100_0000,
              32'h0, 1'b0, 32'h0},
            // done without bootstrap
            '{8'd1,   1'b0, 32'hFFFF_0000, 32'h0001_0000, 1'b1, 1'b0, 32'h0100_0000,
              32'h0, 1'b0, 32'h0},
            // bootstrap replaces the stored next value
            '{8'd1,   1'b0, 32'h0000_8000, 32'hFFFF_8000, 1'b0, 1'b1, 32'h0005_0000,
              32'h0, 1'b0, 32'h0},
            // bootstrap with done: next kept, carry dropped
            '{8'd1,   1'b0, 32'h0003_0000, 32'h0002_0000, 1'b1, 1'b1, 32'hFFFA_0000,
              32'h0, 1'b0, 32'h0},
            // stored extremes flowing through gamma and the carry
            '{8'd255, 1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h8000_0000,
              32'h7FFF_FFFF, 1'b0, 32'h0},
            // bootstrap beats the tail on a final step
            '{8'd0,   1'b1, 32'h8000_0000, 32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF,
              32'h8000_0000, 1'b0, 32'h0},
            '{8'd0,   1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h8000_0000,
              32'h7FFF_FFFF, 1'b0, 32'h0},
            '{8'd128, 1'b0, 32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0, 32'h0,
              1'b0, 32'h0},
            // all ones, rounding of negative products
            '{8'd0,   1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'hFFFF_FFFF,
              32'hFFFF_FFFF, 1'b0, 32'h0},
            // largest tail
            '{8'd2,   1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 32'h0,
              32'h7FFF_FFFF, 1'b0, 32'h0},
            '{8'd2,   1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h5555_5555,
              32'hAAAA_AAAA, 1'b0, 32'h0},
            // new episode on a used column: history discarded
            '{8'd1,   1'b1, 32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, 32'h0, 32'h0,
              1'b1, 32'h0000_0000},
            '{8'd3,   1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0, 32'h0,
              1'b1, 32'hFFFF_FFFF}
        };

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++)
            send_beat(dir_rows[r]);

        for (int p = 0; p < CFG_PHASES; p++)
        begin
            for (int k = 0; k < 8; k++)
                agent_pool[k] = AGENT_W'($urandom_range(0, AGENTS - 1));
            if (p > 0)
            begin
                // sender waits for every advantage before reconfiguring
                drain();
                apply_phase_config(p);
            end
            run_random(p == 0 ? FIRST_RANDOM : PHASE_BEATS,
                       (p == 2 || p == 5) ? 60 : -1);
        end

        drain();
        repeat (2 * PIPE_SETTLE) @(negedge clk);
        if (n_errors == 0)
            $display("gae_advantage_scan verification clean");
        else
            $display("gae_advantage_scan verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver back-pressure
    // ------------------------------------------------------------------
    initial
    begin : out_stall_gen
        int holds_done;
        int g;
        holds_done = 0;
        out_stall  = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_reqs != holds_done)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                g = pick_gap();
                if (g == 0)
                begin
                    out_stall <= 1'b0;
                    // occasional long run with no stall at all
                    if ($urandom_range(0, 19) == 0)
                        repeat ($urandom_range(40, 120)) @(negedge clk);
                    else
                        repeat ($urandom_range(1, 6)) @(negedge clk);
                end
                else
                begin
                    out_stall <= 1'b1;
                    repeat (g) @(negedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output checker: in-order compare against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : adv_check
        adv_exp_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_adv.size() == 0)
            begin
                $display("%0t: unexpected beat: advantage %h agent %0d",
                         $time, advantage, agent_out);
                n_errors++;
            end
            else
            begin
                e = pending_adv.pop_front();
                if (advantage !== e.adv)
                begin
                    $display("%0t: advantage mismatch (agent %0d): expected %h, got %h",
                             $time, e.agent, e.adv, advantage);
                    n_errors++;
                end
                if (agent_out !== e.agent)
                begin
                    $display("%0t: agent_out mismatch: expected %0d, got %0d",
                             $time, e.agent, agent_out);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog: any beat on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles, %0d advantages outstanding",
                     $time, IDLE_LIMIT, pending_adv.size());
            $display("gae_advantage_scan verification failed");
            $finish;
        end
    end

    initial idle_cycles = 0;

endmodule

[gae_advantage_scan.f]
+incdir+hdl
hdl/gae_pkg.sv
hdl/gae_cfg.sv
hdl/gae_advantage_scan.sv
dv/tb_top.sv
